### src/bas_pkg.sv
// Shared types, constants and codes of the bank-aligned synapse placer.
`timescale 1ns / 1ps
`default_nettype none

package bas_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_BANKS   = 64;
    localparam int DEF_NEURON_BITS = 24;
    localparam int DEF_ADDR_BITS   = 24;
    localparam int DEF_COUNT_BITS  = 16;

    // Field widths of the words and registers.
    localparam int CMD_W       = 2;
    localparam int DST_FIELD_W = 24;
    localparam int WEIGHT_W    = 32;
    localparam int SLOT_W      = 24;
    localparam int ROW_W       = 24;
    localparam int BANK_CNT_W  = 7;
    localparam int FILLER_W    = 24;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SYN     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SYN_END = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END     = 2'd2;

    // Register indexes.
    localparam logic REG_BANK_COUNT = 1'b0;
    localparam logic REG_FILLER_ROW = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [DST_FIELD_W-1:0] neuron_dst;
        logic [WEIGHT_W-1:0]    weight_bits;
    } t_in_word;

    typedef struct packed {
        logic                   slot_valid;
        logic [SLOT_W-1:0]      slot_address;
        logic [DST_FIELD_W-1:0] stored_dst;
        logic [WEIGHT_W-1:0]    stored_weight;
        logic                   class_done;
        logic [ROW_W-1:0]       class_end_row;
        logic [FILLER_W-1:0]    fill_value;
        logic                   overflow;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic div_step;
        logic rd;
        logic mul;
        logic fin;
        logic close;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_place;
        logic place;
        logic close;
    } t_dp_status;

    function automatic logic cmd_places(input logic [CMD_W-1:0] cmd);
        return (cmd == CMD_SYN) || (cmd == CMD_SYN_END);
    endfunction

    function automatic logic cmd_closes(input logic [CMD_W-1:0] cmd);
        return cmd != CMD_SYN;
    endfunction

endpackage

`default_nettype wire

### src/bank_aligned_synapse_placer_unit.sv
// Top level of the bank-aligned synapse placer: register port, controller and datapath.
// A synapse word passes through the divider, then the read, multiply and finish steps, and
// a closing command adds a close step; a close-only word goes straight to the close step.
// A new word is taken only once the last has gone to the output register. The restoring
// divider finds the bank and stored destination one quotient bit per cycle.
// Reset clears the bank counts, class maximum and row end, and sets bank_count to 1
// and filler_row to 0; it takes effect at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bank_aligned_synapse_placer_unit #(
    parameter int MAX_BANKS   = bas_pkg::DEF_MAX_BANKS,
    parameter int NEURON_BITS = bas_pkg::DEF_NEURON_BITS,
    parameter int ADDR_BITS   = bas_pkg::DEF_ADDR_BITS,
    parameter int COUNT_BITS  = bas_pkg::DEF_COUNT_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire bas_pkg::t_in_word                i_in,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output bas_pkg::t_out_word                    o_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bas_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bas_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bas_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import bas_pkg::*;

    logic [BANK_CNT_W-1:0] r_bank_count;
    logic [FILLER_W-1:0]   r_filler_row;
    logic                  w_wr;
    logic                  w_reg_sel;
    t_dp_cmd               w_cmd;
    t_dp_status            w_status;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count <= BANK_CNT_W'(1);
            r_filler_row <= '0;
        end else if (w_wr) begin
            unique case (w_reg_sel)
                REG_BANK_COUNT: r_bank_count <= pwdata[BANK_CNT_W-1:0];
                REG_FILLER_ROW: r_filler_row <= pwdata[FILLER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_BANK_COUNT: prdata = APB_DATA_W'(r_bank_count);
            REG_FILLER_ROW: prdata = APB_DATA_W'(r_filler_row);
            default:        prdata = '0;
        endcase
    end

    bas_ctrl #(
        .NEURON_BITS (NEURON_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    bas_dpath #(
        .MAX_BANKS   (MAX_BANKS),
        .NEURON_BITS (NEURON_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_bank_count (r_bank_count),
        .i_filler_row (r_filler_row),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

### src/bas_ctrl.sv
// Controller state machine that sequences one word through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module bas_ctrl #(
    parameter int NEURON_BITS = bas_pkg::DEF_NEURON_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    output logic                    o_valid,
    input  wire logic               i_ready,
    input  wire bas_pkg::t_dp_status i_status,
    output bas_pkg::t_dp_cmd        o_cmd
);
    import bas_pkg::*;

    localparam int DST_W = (NEURON_BITS < DST_FIELD_W) ? NEURON_BITS : DST_FIELD_W;
    localparam int CW    = $clog2(DST_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_MUL,
        S_FIN,
        S_CLOSE,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic            r_out_valid;
    logic            w_accept;
    logic            w_out_free;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = w_accept;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.fin      = (r_state == S_FIN);
        o_cmd.close    = (r_state == S_CLOSE);
        o_cmd.load_out = (r_state == S_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt   <= '0;
                        r_state <= i_status.in_place ? S_DIV : S_CLOSE;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DST_W - 1)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= i_status.close ? S_CLOSE : S_DONE;
                end
                S_CLOSE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // A finished word goes to the output register as soon as it is free.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished word not loaded into the output register");

    // A close-only word skips the divider.
    a_close_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_status.in_place) |=> (r_state == S_CLOSE))
        else $error("close-only word did not go straight to the close step");

    // The divider runs exactly one step per quotient bit.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CW'(DST_W)))
        else $error("divider step count ran past the quotient width");
`endif

endmodule

`default_nettype wire

### src/bas_dpath.sv
// Datapath: bank divider, per-bank fill memory, slot address and class end arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module bas_dpath #(
    parameter int MAX_BANKS   = bas_pkg::DEF_MAX_BANKS,
    parameter int NEURON_BITS = bas_pkg::DEF_NEURON_BITS,
    parameter int ADDR_BITS   = bas_pkg::DEF_ADDR_BITS,
    parameter int COUNT_BITS  = bas_pkg::DEF_COUNT_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire bas_pkg::t_in_word                i_in,
    input  wire logic [bas_pkg::BANK_CNT_W-1:0]   i_bank_count,
    input  wire logic [bas_pkg::FILLER_W-1:0]     i_filler_row,
    input  wire bas_pkg::t_dp_cmd                 i_cmd,
    output bas_pkg::t_dp_status                   o_status,
    output bas_pkg::t_out_word                    o_out
);
    import bas_pkg::*;

    localparam int DST_W = (NEURON_BITS < DST_FIELD_W) ? NEURON_BITS : DST_FIELD_W;
    localparam int NB_W  = BANK_CNT_W;
    localparam int BI_W  = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int WW    = ADDR_BITS + COUNT_BITS + 1;
    localparam int PW    = WW + NB_W;
    localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

    logic                   r_place;
    logic                   r_close;
    logic [NB_W-1:0]        r_nb;
    logic [DST_W-1:0]       r_quo;
    logic [NB_W-1:0]        r_rem;
    logic [WEIGHT_W-1:0]    r_wt;
    logic [COUNT_BITS-1:0]  r_mem [MAX_BANKS];
    logic [MAX_BANKS-1:0]   r_vld;
    logic [COUNT_BITS-1:0]  r_rdata;
    logic                   r_rvld;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic [PW-1:0]          r_prod;
    logic [COUNT_BITS-1:0]  r_class_max;
    logic [ADDR_BITS-1:0]   r_rows;
    logic [ADDR_BITS-1:0]   r_addr;
    logic                   r_ovf;
    t_out_word              r_out;

    logic [NB_W-1:0]        n_nb;
    logic [NB_W:0]          w_trial;
    logic                   w_qbit;
    logic [BI_W-1:0]        w_bank;
    logic [COUNT_BITS-1:0]  w_cnt;
    logic [WW-1:0]          w_base;
    logic [PW-1:0]          w_sum;
    logic                   w_addr_ovf;
    logic                   w_cnt_ovf;
    logic [COUNT_BITS-1:0]  n_fill;
    logic [WW-1:0]          w_end;
    logic                   w_end_ovf;

    // Out-of-range bank counts are clamped to 1..MAX_BANKS.
    always_comb begin
        if (i_bank_count == '0) begin
            n_nb = NB_W'(1);
        end else if (i_bank_count > NB_W'(MAX_BANKS)) begin
            n_nb = NB_W'(MAX_BANKS);
        end else begin
            n_nb = i_bank_count;
        end
    end

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    assign w_trial = {r_rem, r_quo[DST_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_nb});

    assign w_bank     = r_rem[BI_W-1:0];
    assign w_cnt      = r_rvld ? r_rdata : '0;
    assign w_base     = WW'(r_rows) + WW'(w_cnt);
    assign w_sum      = r_prod + PW'(w_bank);
    assign w_addr_ovf = (w_sum > PW'(ADDR_MAX));
    assign w_cnt_ovf  = (r_cnt == '1);
    assign n_fill     = w_cnt_ovf ? r_cnt : r_cnt + 1'b1;
    assign w_end      = WW'(r_rows) + WW'(r_class_max);
    assign w_end_ovf  = (w_end > WW'(ADDR_MAX));

    assign o_status.in_place = cmd_places(i_in.command);
    assign o_status.place    = r_place;
    assign o_status.close    = r_close;
    assign o_out             = r_out;

    // Class state with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_class_max <= '0;
            r_rows      <= '0;
        end else begin
            if (i_cmd.fin) begin
                r_vld[w_bank] <= 1'b1;
                if (n_fill > r_class_max) begin
                    r_class_max <= n_fill;
                end
            end
            if (i_cmd.close) begin
                r_vld       <= '0;
                r_class_max <= '0;
                r_rows      <= w_end_ovf ? ADDR_MAX : ADDR_BITS'(w_end);
            end
        end
    end

    // Per-bank fill memory, one port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_mem[w_bank] <= n_fill;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_bank];
            r_rvld  <= r_vld[w_bank];
        end
    end

    // Working registers of the word in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_place <= cmd_places(i_in.command);
            r_close <= cmd_closes(i_in.command);
            r_nb    <= n_nb;
            r_quo   <= DST_W'(i_in.neuron_dst);
            r_rem   <= '0;
            r_wt    <= i_in.weight_bits;
            r_ovf   <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[DST_W-2:0], w_qbit};
            r_rem <= w_qbit ? NB_W'(w_trial - {1'b0, r_nb}) : NB_W'(w_trial);
        end
        if (i_cmd.mul) begin
            r_cnt  <= w_cnt;
            r_prod <= PW'(w_base) * PW'(r_nb);
        end
        if (i_cmd.fin) begin
            r_addr <= w_addr_ovf ? ADDR_MAX : ADDR_BITS'(w_sum);
            r_ovf  <= r_ovf | w_addr_ovf | w_cnt_ovf;
        end
        if (i_cmd.close) begin
            r_ovf <= r_ovf | w_end_ovf;
        end
        if (i_cmd.load_out) begin
            r_out.slot_valid    <= r_place;
            r_out.slot_address  <= r_place ? SLOT_W'(r_addr) : '0;
            r_out.stored_dst    <= r_place ? DST_FIELD_W'(r_quo) : '0;
            r_out.stored_weight <= r_place ? r_wt : '0;
            r_out.class_done    <= r_close;
            r_out.class_end_row <= r_close ? ROW_W'(r_rows) : '0;
            r_out.fill_value    <= r_close ? i_filler_row : '0;
            r_out.overflow      <= r_ovf;
        end
    end

`ifndef SYNTH
    // The remainder after the divide selects an existing bank.
    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_rem < r_nb))
        else $error("bank index not below the bank count");

    // Closing a class empties every bank count and the class maximum.
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.close |=> ((r_vld == '0) && (r_class_max == '0)))
        else $error("bank counts not cleared after class close");

    // A placed synapse leaves the class maximum at one or more.
    a_fin_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_class_max != '0))
        else $error("class maximum still zero after a placement");
`endif

endmodule

`default_nettype wire

### test/bank_aligned_synapse_placer_unit_test.sv
// Self-checking testbench for the bank-aligned synapse placer with a built-in placement predictor.
`timescale 1ns / 1ps

module bank_aligned_synapse_placer_unit_test;
    import bas_pkg::*;

    localparam longint unsigned BANK_LIMIT = DEF_MAX_BANKS;
    localparam longint unsigned COUNT_MAX  = (64'd1 << DEF_COUNT_BITS) - 1;
    localparam longint unsigned SLOT_MAX   = (64'd1 << DEF_ADDR_BITS) - 1;
    localparam longint unsigned DST_MAX    = (64'd1 << DST_FIELD_W) - 1;
    // The fourth command code is not named by the block; it closes a class like CMD_END.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 1625;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        t_in_word word;
        bit       drain_first;
    } t_send_entry;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in_word              i_in = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_word             o_out;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bank_aligned_synapse_placer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Predictor state, a mirror of the block's registers and counters.
    bit [BANK_CNT_W-1:0]     banks_cfg = 7'd1;
    bit [FILLER_W-1:0]       filler_cfg = '0;
    bit [DEF_COUNT_BITS-1:0] fill_count [DEF_MAX_BANKS];
    bit [DEF_COUNT_BITS-1:0] class_peak = '0;
    bit [DEF_ADDR_BITS-1:0]  rows_done = '0;

    t_send_entry words_to_send [$];
    t_out_word   placements_due [$];
    t_out_word   want;

    int mismatches = 0;
    int results_seen = 0;
    int slots_placed = 0;
    int classes_closed = 0;
    int overflows_seen = 0;
    int words_queued = 0;
    int bank_settings = 0;
    int gap_left = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int stall_left = 0;
    int unsigned cycle_count = 0;

    initial begin
        foreach (fill_count[k]) fill_count[k] = '0;
    end

    function automatic longint unsigned active_banks();
        if (banks_cfg == 0) return 1;
        if (banks_cfg > BANK_LIMIT) return BANK_LIMIT;
        return banks_cfg;
    endfunction

    function automatic t_out_word compute_placement(input t_in_word w);
        longint unsigned nb, bank, cnt, nxt, slot, rows;
        t_out_word r;
        r = '0;
        nb = active_banks();
        if (w.command == CMD_SYN || w.command == CMD_SYN_END) begin
            bank = w.neuron_dst % nb;
            cnt = fill_count[bank];
            slot = rows_done * nb + nb * cnt + bank;
            if (slot > SLOT_MAX) begin
                slot = SLOT_MAX;
                r.overflow = 1'b1;
            end
            if (cnt >= COUNT_MAX) begin
                nxt = COUNT_MAX;
                r.overflow = 1'b1;
            end else begin
                nxt = cnt + 1;
            end
            fill_count[bank] = nxt[DEF_COUNT_BITS-1:0];
            if (nxt > class_peak) class_peak = nxt[DEF_COUNT_BITS-1:0];
            r.slot_valid = 1'b1;
            r.slot_address = slot[SLOT_W-1:0];
            r.stored_dst = DST_FIELD_W'(w.neuron_dst / nb);
            r.stored_weight = w.weight_bits;
        end
        if (w.command != CMD_SYN) begin
            rows = longint'(rows_done) + longint'(class_peak);
            if (rows > SLOT_MAX) begin
                rows = SLOT_MAX;
                r.overflow = 1'b1;
            end
            rows_done = rows[DEF_ADDR_BITS-1:0];
            r.class_done = 1'b1;
            r.class_end_row = rows[ROW_W-1:0];
            r.fill_value = filler_cfg;
            foreach (fill_count[k]) fill_count[k] = '0;
            class_peak = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_seen, name, exp_val, got_val);
        end
    endtask

    // Sender: bursts of words separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                placements_due.push_back(compute_placement(i_in));
            end
            if (i_valid && !o_ready) begin
                // The word is still waiting; keep it on the bus unchanged.
            end else if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (words_to_send.size() != 0 &&
                         !(words_to_send[0].drain_first && placements_due.size() != 0)) begin
                i_in <= words_to_send[0].word;
                words_to_send.pop_front();
                i_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 5);
                        8: gap_left = $urandom_range(6, 35);
                        default: gap_left = $urandom_range(36, 70);
                    endcase
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                              : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each word against the oldest prediction and stalls in modes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            cycle_count++;
            if (o_valid && i_ready) begin
                if (placements_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result word 0x%0h arrived with no prediction pending", o_out);
                end else begin
                    want = placements_due.pop_front();
                    check_field("slot_valid", want.slot_valid, o_out.slot_valid);
                    check_field("slot_address", want.slot_address, o_out.slot_address);
                    check_field("stored_dst", want.stored_dst, o_out.stored_dst);
                    check_field("stored_weight", want.stored_weight, o_out.stored_weight);
                    check_field("class_done", want.class_done, o_out.class_done);
                    check_field("class_end_row", want.class_end_row, o_out.class_end_row);
                    check_field("fill_value", want.fill_value, o_out.fill_value);
                    check_field("overflow", want.overflow, o_out.overflow);
                    if (want.slot_valid) slots_placed++;
                    if (want.class_done) classes_closed++;
                    if (want.overflow) overflows_seen++;
                end
                results_seen++;
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 4);
                stall_left = $urandom_range(50, 600);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= ($urandom_range(0, 3) == 0);
                3: i_ready <= cycle_count[0];
                default: i_ready <= (cycle_count % 40 == 0);
            endcase
        end
    end

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * reg_idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_BANK_COUNT) begin
            banks_cfg = value[BANK_CNT_W-1:0];
            bank_settings++;
        end else begin
            filler_cfg = value[FILLER_W-1:0];
        end
    endtask

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input longint unsigned dst,
                              input logic [31:0] wt, input bit drain_first);
        t_send_entry e;
        e.word.command = cmd;
        e.word.neuron_dst = dst[DST_FIELD_W-1:0];
        e.word.weight_bits = wt;
        e.drain_first = drain_first;
        words_to_send.push_back(e);
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_to_send.size() != 0 || i_valid || placements_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic longint unsigned pick_dst(input int style);
        longint unsigned nb, d;
        nb = active_banks();
        d = $urandom() & DST_MAX;
        case (style)
            1: begin
                // Crowd a class into its first and last bank so the counts build up.
                d = d - d % nb + (($urandom_range(0, 1) == 0) ? 0 : nb - 1);
                if (d > DST_MAX) d = d - nb;
            end
            2: d = $urandom_range(0, 4 * nb);
            default: ;
        endcase
        return d;
    endfunction

    // A class of n synapses, closed in one of three ways or left open.
    task automatic queue_class(input int n, input bit closing);
        int style, how;
        bit hold;
        style = $urandom_range(0, 2);
        how = (n == 0) ? $urandom_range(1, 2) : $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            hold = ($urandom_range(0, 149) == 0);
            if (closing && how == 0 && k == n - 1)
                queue_word(CMD_SYN_END, pick_dst(style), $urandom(), hold);
            else
                queue_word(CMD_SYN, pick_dst(style), $urandom(), hold);
        end
        if (closing && how == 1) queue_word(CMD_END, $urandom() & DST_MAX, $urandom(), 1'b0);
        if (closing && how == 2) queue_word(CMD_SPARE, $urandom() & DST_MAX, $urandom(), 1'b0);
    endtask

    initial begin
        int bank_plan [12] = '{1, 64, 0, 127, 65, 2, 3, 7, 16, 33, 63, 8};
        int phase, start_count, target, n;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one bank, filler zero.
        queue_word(CMD_SYN, 0, 32'h0000_0000, 1'b0);
        queue_word(CMD_SYN_END, DST_MAX, 32'hFFFF_FFFF, 1'b0);
        wait_idle();

        write_reg(REG_BANK_COUNT, 32'd64);
        write_reg(REG_FILLER_ROW, 32'h00FF_FFFF);
        queue_word(CMD_SYN, 0, 32'h0000_0000, 1'b0);
        queue_word(CMD_SYN, 63, 32'hFFFF_FFFF, 1'b0);
        queue_word(CMD_SYN, DST_MAX, 32'hA5A5_A5A5, 1'b0);
        queue_word(CMD_SYN, 64, 32'h5A5A_5A5A, 1'b0);
        queue_word(CMD_SYN_END, 128, 32'h8000_0001, 1'b0);
        queue_word(CMD_END, DST_MAX, 32'hFFFF_FFFF, 1'b0);
        queue_word(CMD_SPARE, 0, 32'h0, 1'b0);
        queue_word(CMD_SYN, 1, 32'h1234_5678, 1'b0);
        wait_idle();

        // The bank count changes while a class is still open.
        write_reg(REG_BANK_COUNT, 32'd5);
        queue_word(CMD_SYN, 6, 32'h0F0F_0F0F, 1'b0);
        queue_word(CMD_SYN_END, 7, 32'hF0F0_F0F0, 1'b0);
        wait_idle();

        // Zero banks act as one, and counts above the bank limit are clamped.
        write_reg(REG_BANK_COUNT, 32'd0);
        write_reg(REG_FILLER_ROW, 32'h0);
        queue_word(CMD_SYN, 12345, 32'hDEAD_BEEF, 1'b0);
        queue_word(CMD_SYN_END, DST_MAX, 32'h0000_0001, 1'b0);
        wait_idle();
        write_reg(REG_BANK_COUNT, 32'd127);
        queue_word(CMD_SYN, DST_MAX, 32'h7FFF_FFFF, 1'b0);
        queue_word(CMD_SYN, 63, 32'hC3C3_C3C3, 1'b0);
        queue_word(CMD_SPARE, 0, 32'h0, 1'b0);
        wait_idle();
        write_reg(REG_BANK_COUNT, 32'd65);
        queue_word(CMD_SYN, 64, 32'h3C3C_3C3C, 1'b0);
        queue_word(CMD_END, 0, 32'h0, 1'b0);
        wait_idle();

        // Saturation of the bank counters and slot addresses would take tens of
        // thousands of synapses in one class, beyond this run; the predictor covers it.
        start_count = words_queued;
        phase = 0;
        while (words_queued - start_count < RANDOM_WORDS) begin
            write_reg(REG_BANK_COUNT,
                      (phase < 12) ? bank_plan[phase] : $urandom_range(0, 127));
            case (phase % 3)
                0: write_reg(REG_FILLER_ROW, 32'h0);
                1: write_reg(REG_FILLER_ROW, 32'h00FF_FFFF);
                default: write_reg(REG_FILLER_ROW, $urandom() & DST_MAX);
            endcase
            target = words_queued + $urandom_range(80, 180);
            if (target > start_count + RANDOM_WORDS) target = start_count + RANDOM_WORDS;
            while (words_queued < target) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                queue_class(n, 1'b1);
            end
            // Some phases end with a class still open across the next setting.
            if ($urandom_range(0, 3) == 0) queue_class($urandom_range(1, 6), 1'b0);
            wait_idle();
            phase++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d results: %0d slots placed, %0d classes closed, %0d overflows.",
                 results_seen, slots_placed, classes_closed, overflows_seen);
        $display("Stimulus ran through %0d bank count settings, including 0, 64 and 127.",
                 bank_settings);
        if (mismatches == 0 && placements_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d predictions never matched by a result.",
                     mismatches, placements_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
